// ===== rtl/cti_pkg.sv =====
`default_nettype none
package cti_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 4096;
  localparam int TABLE_COUNT_W = 13;
  localparam int TEMP_W = 32;
  localparam int RATE_W = 32;
  localparam int FRAC_W = 16;
  localparam int INDEX_W = 12;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [TABLE_COUNT_W-1:0] RST_TABLE_COUNT = '0;
  localparam logic [TEMP_W-1:0] RST_MIN_TEMP = 32'd20000;
  localparam logic [FRAC_W-1:0] RST_METAL_FRACTION = 16'd655;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_METAL_FRACTION = 2'd2;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_INTERP = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_BELOW = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_CLAMP_LO = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_CLAMP_HI = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 3'd4;

  typedef struct packed {
    logic [TEMP_W-1:0] temp;
    logic [RATE_W-1:0] base;
    logic [RATE_W-1:0] coef;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [4:0] {
    OP_NOP,
    OP_INIT,
    OP_RDLO,
    OP_CAPLO,
    OP_CAPHI,
    OP_RATEHI,
    OP_SRD,
    OP_SCMP,
    OP_MULA,
    OP_MULB,
    OP_ACCB,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_RESQ,
    OP_CLAMPLO,
    OP_CLAMPHI,
    OP_LORATE,
    OP_SATMAX,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NOSTART,
    C_EARLY,
    C_LT_LO,
    C_GT_HI,
    C_ONE,
    C_ADJ,
    C_DZERO,
    C_OVF,
    C_DIVRUN,
    C_OUTBUSY
  } cond_t;

  localparam int PC_W = 5;

  localparam logic [PC_W-1:0] PC_IDLE = 5'd0;
  localparam logic [PC_W-1:0] PC_INIT = 5'd1;
  localparam logic [PC_W-1:0] PC_RD0 = 5'd2;
  localparam logic [PC_W-1:0] PC_CAP0L = 5'd3;
  localparam logic [PC_W-1:0] PC_CAP0H = 5'd4;
  localparam logic [PC_W-1:0] PC_RATE0 = 5'd5;
  localparam logic [PC_W-1:0] PC_TSTHI = 5'd6;
  localparam logic [PC_W-1:0] PC_TSTONE = 5'd7;
  localparam logic [PC_W-1:0] PC_SRD = 5'd8;
  localparam logic [PC_W-1:0] PC_SCMP = 5'd9;
  localparam logic [PC_W-1:0] PC_RDB = 5'd10;
  localparam logic [PC_W-1:0] PC_CAPBL = 5'd11;
  localparam logic [PC_W-1:0] PC_CAPBH = 5'd12;
  localparam logic [PC_W-1:0] PC_RATEB = 5'd13;
  localparam logic [PC_W-1:0] PC_MULA = 5'd14;
  localparam logic [PC_W-1:0] PC_MULB = 5'd15;
  localparam logic [PC_W-1:0] PC_ACCB = 5'd16;
  localparam logic [PC_W-1:0] PC_DIVINIT = 5'd17;
  localparam logic [PC_W-1:0] PC_DIV = 5'd18;
  localparam logic [PC_W-1:0] PC_RESQ = 5'd19;
  localparam logic [PC_W-1:0] PC_CLAMPLO = 5'd20;
  localparam logic [PC_W-1:0] PC_CLAMPHI = 5'd21;
  localparam logic [PC_W-1:0] PC_LORATE = 5'd22;
  localparam logic [PC_W-1:0] PC_SATMAX = 5'd23;
  localparam logic [PC_W-1:0] PC_EMIT = 5'd24;
  localparam logic [PC_W-1:0] PC_LAST = PC_EMIT;

  typedef struct packed {
    op_t op;
    cond_t cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic early;
    logic lt_lo;
    logic gt_hi;
    logic one;
    logic adj;
    logic dzero;
    logic ovf;
    logic divrun;
    logic outbusy;
  } flags_t;

  function automatic logic [RATE_W-1:0] sat33(logic [RATE_W:0] v);
    return v[RATE_W] ? '1 : v[RATE_W-1:0];
  endfunction

  // control store; falling past the last step returns to idle
  function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
    ctrl_t c;
    case (pc)
      PC_IDLE:    c = '{op: OP_NOP,     cond: C_NOSTART, target: PC_IDLE};
      PC_INIT:    c = '{op: OP_INIT,    cond: C_EARLY,   target: PC_EMIT};
      PC_RD0:     c = '{op: OP_RDLO,    cond: C_NEXT,    target: PC_IDLE};
      PC_CAP0L:   c = '{op: OP_CAPLO,   cond: C_NEXT,    target: PC_IDLE};
      PC_CAP0H:   c = '{op: OP_CAPHI,   cond: C_NEXT,    target: PC_IDLE};
      PC_RATE0:   c = '{op: OP_RATEHI,  cond: C_LT_LO,   target: PC_CLAMPLO};
      PC_TSTHI:   c = '{op: OP_NOP,     cond: C_GT_HI,   target: PC_CLAMPHI};
      PC_TSTONE:  c = '{op: OP_NOP,     cond: C_ONE,     target: PC_LORATE};
      PC_SRD:     c = '{op: OP_SRD,     cond: C_ADJ,     target: PC_RDB};
      PC_SCMP:    c = '{op: OP_SCMP,    cond: C_ALWAYS,  target: PC_SRD};
      PC_RDB:     c = '{op: OP_RDLO,    cond: C_NEXT,    target: PC_IDLE};
      PC_CAPBL:   c = '{op: OP_CAPLO,   cond: C_NEXT,    target: PC_IDLE};
      PC_CAPBH:   c = '{op: OP_CAPHI,   cond: C_NEXT,    target: PC_IDLE};
      PC_RATEB:   c = '{op: OP_RATEHI,  cond: C_NEXT,    target: PC_IDLE};
      PC_MULA:    c = '{op: OP_MULA,    cond: C_DZERO,   target: PC_LORATE};
      PC_MULB:    c = '{op: OP_MULB,    cond: C_NEXT,    target: PC_IDLE};
      PC_ACCB:    c = '{op: OP_ACCB,    cond: C_NEXT,    target: PC_IDLE};
      PC_DIVINIT: c = '{op: OP_DIVINIT, cond: C_OVF,     target: PC_SATMAX};
      PC_DIV:     c = '{op: OP_DIVSTEP, cond: C_DIVRUN,  target: PC_DIV};
      PC_RESQ:    c = '{op: OP_RESQ,    cond: C_ALWAYS,  target: PC_EMIT};
      PC_CLAMPLO: c = '{op: OP_CLAMPLO, cond: C_ALWAYS,  target: PC_EMIT};
      PC_CLAMPHI: c = '{op: OP_CLAMPHI, cond: C_ALWAYS,  target: PC_EMIT};
      PC_LORATE:  c = '{op: OP_LORATE,  cond: C_ALWAYS,  target: PC_EMIT};
      PC_SATMAX:  c = '{op: OP_SATMAX,  cond: C_NEXT,    target: PC_IDLE};
      PC_EMIT:    c = '{op: OP_EMIT,    cond: C_OUTBUSY, target: PC_EMIT};
      default:    c = '{op: OP_NOP,     cond: C_ALWAYS,  target: PC_IDLE};
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cti_if.sv =====
`default_nettype none
interface cti_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic [cti_pkg::INDEX_W-1:0] entry_index;
  logic [cti_pkg::TEMP_W-1:0] temperature;
  logic [cti_pkg::RATE_W-1:0] base_rate;
  logic [cti_pkg::RATE_W-1:0] metal_coef;

  modport source (
    output valid, kind, entry_index, temperature, base_rate, metal_coef,
    input ready
  );
  modport sink (
    input valid, kind, entry_index, temperature, base_rate, metal_coef,
    output ready
  );
endinterface

interface cti_out_if;
  logic valid;
  logic ready;
  logic [cti_pkg::RATE_W-1:0] cooling_rate;
  logic [cti_pkg::STATUS_W-1:0] range_status;

  modport source (output valid, cooling_rate, range_status, input ready);
  modport sink (input valid, cooling_rate, range_status, output ready);
endinterface

interface cti_cfg_if;
  logic valid;
  logic ready;
  logic [cti_pkg::CFG_IDX_W-1:0] index;
  logic [cti_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/cti_ram.sv =====
`default_nettype none
module cti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/cti_useq.sv =====
`default_nettype none
module cti_useq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cti_pkg::flags_t flags,
  output cti_pkg::ctrl_t       ctrl,
  output logic                 idle
);

  import cti_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic taken;

  assign ctrl = ucode(pc);
  assign idle = (pc == PC_IDLE);

  always_comb begin
    case (ctrl.cond)
      C_NEXT:    taken = 1'b0;
      C_ALWAYS:  taken = 1'b1;
      C_NOSTART: taken = !flags.start;
      C_EARLY:   taken = flags.early;
      C_LT_LO:   taken = flags.lt_lo;
      C_GT_HI:   taken = flags.gt_hi;
      C_ONE:     taken = flags.one;
      C_ADJ:     taken = flags.adj;
      C_DZERO:   taken = flags.dzero;
      C_OVF:     taken = flags.ovf;
      C_DIVRUN:  taken = flags.divrun;
      C_OUTBUSY: taken = flags.outbusy;
      default:   taken = 1'b1;
    endcase
  end

  always_comb begin
    if (taken) begin
      pc_next = ctrl.target;
    end else if (pc == PC_LAST) begin
      pc_next = PC_IDLE;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cti_dp.sv =====
`default_nettype none
module cti_dp #(
  parameter int TABLE_DEPTH = cti_pkg::DEFAULT_TABLE_DEPTH,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire cti_pkg::ctrl_t                    ctrl,
  input  wire logic                              start,
  input  wire logic [cti_pkg::TEMP_W-1:0]        query_temp,
  input  wire logic [cti_pkg::TABLE_COUNT_W-1:0] table_count,
  input  wire logic [cti_pkg::TEMP_W-1:0]        min_temp,
  input  wire logic [cti_pkg::FRAC_W-1:0]        metal_fraction,
  output logic      [AW-1:0]                     raddr,
  input  wire logic [cti_pkg::ENTRY_W-1:0]       rdata,
  output cti_pkg::flags_t                        flags,
  cti_out_if.source                              rsp
);

  import cti_pkg::*;

  localparam int CW = (TABLE_COUNT_W > AW + 1) ? TABLE_COUNT_W : AW + 1;

  entry_t rd;
  logic [TEMP_W-1:0] t_q, tlo, thi, wlo, whi, dlt;
  logic [RATE_W-1:0] blo, bhi, plo, phi;
  logic [RATE_W:0] rlo, rhi;
  logic [AW-1:0] lo, hi, mid;
  logic [AW:0] lo_sum;
  logic [CW-1:0] cnt_ext, depth_c, n_cl;
  logic [FRAC_W+RATE_W-1:0] mprod;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p, m;
  logic [65:0] acc;
  logic [31:0] rem, quo;
  logic [4:0] dcnt;
  logic [32:0] dsh, dsub;
  logic dge, below, empty, busy;
  logic [RATE_W-1:0] res_rate, out_rate;
  logic [STATUS_W-1:0] res_status, out_status;
  logic out_valid;

  assign rd = entry_t'(rdata);

  assign cnt_ext = CW'(table_count);
  assign depth_c = CW'(TABLE_DEPTH);
  assign n_cl = (cnt_ext > depth_c) ? depth_c : cnt_ext;

  assign lo_sum = {1'b0, lo} + {1'b0, hi};
  assign mid = lo_sum[AW:1];

  assign wlo = thi - t_q;
  assign whi = t_q - tlo;
  assign dlt = thi - tlo;

  assign mprod = (FRAC_W+RATE_W)'(metal_fraction) * (FRAC_W+RATE_W)'(rd.coef);

  assign mul_a = (ctrl.op == OP_MULA) ? rlo[31:0] : rhi[31:0];
  assign mul_b = (ctrl.op == OP_MULA) ? wlo : whi;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // restoring divide, one quotient bit per step
  assign dsh = {rem, quo[31]};
  assign dsub = dsh - {1'b0, dlt};
  assign dge = (dsh >= {1'b0, dlt});

  assign below = (t_q < min_temp);
  assign empty = (table_count == '0);
  assign busy = out_valid && !rsp.ready;

  always_comb begin
    case (ctrl.op)
      OP_CAPLO: raddr = hi;
      OP_SRD:   raddr = mid;
      default:  raddr = lo;
    endcase
  end

  always_comb begin
    flags.start   = start;
    flags.early   = below || empty;
    flags.lt_lo   = (t_q < tlo);
    flags.gt_hi   = (t_q > thi);
    flags.one     = (n_cl == CW'(1));
    flags.adj     = (({1'b0, lo} + (AW+1)'(1)) == {1'b0, hi});
    flags.dzero   = (dlt == '0);
    flags.ovf     = (acc[65:32] >= {2'b0, dlt});
    flags.divrun  = (dcnt != 5'd31);
    flags.outbusy = busy;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      t_q <= query_temp;
    end
    case (ctrl.op)
      OP_INIT: begin
        lo <= '0;
        hi <= AW'(n_cl - CW'(1));
        res_rate <= '0;
        res_status <= below ? STATUS_BELOW : STATUS_EMPTY;
      end
      OP_CAPLO: begin
        tlo <= rd.temp;
        blo <= rd.base;
        plo <= mprod[FRAC_W+RATE_W-1:FRAC_W];
      end
      OP_CAPHI: begin
        thi <= rd.temp;
        bhi <= rd.base;
        phi <= mprod[FRAC_W+RATE_W-1:FRAC_W];
        rlo <= {1'b0, blo} + {1'b0, plo};
      end
      OP_RATEHI: rhi <= {1'b0, bhi} + {1'b0, phi};
      OP_SCMP: begin
        if (t_q <= rd.temp) begin
          hi <= mid;
        end else begin
          lo <= mid;
        end
      end
      OP_MULA: m <= mul_p;
      OP_MULB: begin
        acc <= 66'(m) + (rlo[32] ? {2'b0, wlo, 32'b0} : 66'd0);
        m <= mul_p;
      end
      OP_ACCB: acc <= acc + 66'(m) + (rhi[32] ? {2'b0, whi, 32'b0} : 66'd0);
      OP_DIVINIT: begin
        rem <= acc[63:32];
        quo <= acc[31:0];
        dcnt <= '0;
      end
      OP_DIVSTEP: begin
        rem <= dge ? dsub[31:0] : dsh[31:0];
        quo <= {quo[30:0], dge};
        dcnt <= dcnt + 5'd1;
      end
      OP_RESQ: begin
        res_rate <= quo;
        res_status <= STATUS_INTERP;
      end
      OP_CLAMPLO: begin
        res_rate <= sat33(rlo);
        res_status <= STATUS_CLAMP_LO;
      end
      OP_CLAMPHI: begin
        res_rate <= sat33(rhi);
        res_status <= STATUS_CLAMP_HI;
      end
      OP_LORATE: begin
        res_rate <= sat33(rlo);
        res_status <= STATUS_INTERP;
      end
      OP_SATMAX: begin
        res_rate <= '1;
        res_status <= STATUS_INTERP;
      end
      default: ;
    endcase
  end

  // result register: frees the sequencer while a beat waits downstream
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (ctrl.op == OP_EMIT && !busy) begin
        out_valid <= 1'b1;
        out_rate <= res_rate;
        out_status <= res_status;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.cooling_rate = out_rate;
  assign rsp.range_status = out_status;

endmodule
`default_nettype wire

// ===== rtl/cooling_table_interpolator.sv =====
`default_nettype none
// Cooling-rate table lookup. A load beat writes one table entry (temperature,
// base rate, metal coefficient). A query beat is run by a small microcode
// program over one table RAM read port: floor and empty-table queries answer
// from the first step, clamped and single-entry queries after the two end
// entries are read, and interpolated queries after a binary search over the
// n entries in use (one RAM read per search step) and a one-bit-per-cycle
// 32-step divider. Queries are taken one at a time; the next beat is
// accepted as soon as the previous answer sits in the output register.
// Configuration is written through the cfg channel, which is always ready.
module cooling_table_interpolator #(
  parameter int TABLE_DEPTH = cti_pkg::DEFAULT_TABLE_DEPTH
) (
  input wire logic clk,
  input wire logic rst,
  cti_in_if.sink   req,
  cti_out_if.source rsp,
  cti_cfg_if.sink  cfg
);

  import cti_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [TABLE_COUNT_W-1:0] table_count;
  logic [TEMP_W-1:0] min_temp;
  logic [FRAC_W-1:0] metal_fraction;
  logic idle, start, we;
  logic [AW-1:0] raddr;
  logic [ENTRY_W-1:0] rdata;
  entry_t wentry;
  ctrl_t ctrl;
  flags_t flags;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_count <= RST_TABLE_COUNT;
      min_temp <= RST_MIN_TEMP;
      metal_fraction <= RST_METAL_FRACTION;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_TABLE_COUNT:    table_count <= cfg.data[TABLE_COUNT_W-1:0];
        CFG_MIN_TEMP:       min_temp <= cfg.data[TEMP_W-1:0];
        CFG_METAL_FRACTION: metal_fraction <= cfg.data[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  assign req.ready = idle;
  assign start = req.valid && idle && (req.kind == KIND_QUERY);
  assign we = req.valid && idle && (req.kind == KIND_LOAD)
              && (32'(req.entry_index) < 32'(TABLE_DEPTH));

  assign wentry.temp = req.temperature;
  assign wentry.base = req.base_rate;
  assign wentry.coef = req.metal_coef;

  cti_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(AW'(req.entry_index)),
    .wdata(wentry),
    .raddr(raddr),
    .rdata(rdata)
  );

  cti_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .flags(flags),
    .ctrl (ctrl),
    .idle (idle)
  );

  cti_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .start         (start),
    .query_temp    (req.temperature),
    .table_count   (table_count),
    .min_temp      (min_temp),
    .metal_fraction(metal_fraction),
    .raddr         (raddr),
    .rdata         (rdata),
    .flags         (flags),
    .rsp           (rsp)
  );

endmodule
`default_nettype wire
